// ===== hw/rtl/rch_pkg.sv =====
// Shared types and constants for the reader command handshake block.
`default_nettype none

package rch_pkg;

  // Input item function codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_BYTE  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;
  localparam logic [1:0] FUNC_LOAD  = 2'd3;

  // Completion status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_WRONG   = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_HANDSHAKE_TO = 3'd0;
  localparam logic [2:0] CFG_EXECUTE_TO   = 3'd1;
  localparam logic [2:0] CFG_RECEIVE_TO   = 3'd2;
  localparam logic [2:0] CFG_ACK_TO       = 3'd3;
  localparam logic [2:0] CFG_SEND_CODE    = 3'd4;

  // Configuration reset values
  localparam logic [9:0] HANDSHAKE_TO_RST = 10'd200;
  localparam logic [9:0] EXECUTE_TO_RST   = 10'd300;
  localparam logic [9:0] RECEIVE_TO_RST   = 10'd600;
  localparam logic [9:0] ACK_TO_RST       = 10'd100;
  localparam logic [7:0] SEND_CODE_RST    = 8'h15;

  // Protocol bytes
  localparam logic [7:0] START_BYTE = 8'h2A;
  localparam logic [7:0] ACK_BYTE   = 8'hBB;

  // Timer saturation and payload burst ceiling
  localparam logic [9:0] ELAPSED_MAX = 10'h3FF;
  localparam int unsigned MAX_BURST  = 8;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] cmd_code;
    logic [7:0] data_length;
    logic [7:0] byte_value;
    logic [2:0] payload_index;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_out;
    logic       done_res;
    logic [1:0] status;
    logic       checksum_ok;
    logic       last;
  } out_item_t;

  // What follows the evaluation of an item
  typedef enum logic [1:0] {
    FOLLOW_NONE,
    FOLLOW_DONE,
    FOLLOW_BURST
  } follow_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic apply;
    logic burst_read;
    logic push_payload;
    logic push_done;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic    out_free;
    follow_e follow;
    logic    burst_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rch_ctrl.sv =====
// Sequencing controller for the reader command handshake block.
`default_nettype none

module rch_ctrl
  import rch_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_BREAD,
    ST_BPUSH,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  // Commands and next state
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    state_d    = state_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (stat_i.out_free) begin
          cmd_o.apply = 1'b1;
          unique case (stat_i.follow)
            FOLLOW_DONE:  state_d = ST_DONE;
            FOLLOW_BURST: state_d = ST_BREAD;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_BREAD: begin
        cmd_o.burst_read = 1'b1;
        state_d          = ST_BPUSH;
      end
      ST_BPUSH: begin
        if (stat_i.out_free) begin
          cmd_o.push_payload = 1'b1;
          state_d = stat_i.burst_last ? ST_IDLE : ST_BREAD;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.push_done = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rch_datapath.sv =====
// Protocol state, timers, checksum, payload store and output register.
`default_nettype none

module rch_datapath
  import rch_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire in_item_t   in_item_i,
  input  wire dp_cmd_t    cmd_i,
  output dp_stat_t        stat_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [9:0] cfg_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_item_t       out_item_o
);

  localparam int unsigned ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int unsigned WIDE_W = 7;
  localparam logic [7:0] BURST_LIM =
      (PAYLOAD_DEPTH < MAX_BURST) ? 8'(PAYLOAD_DEPTH) : 8'(MAX_BURST);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_INIT,
    PH_ECHO,
    PH_EXEC,
    PH_RECV,
    PH_ACK
  } phase_e;

  // Configuration registers
  logic [9:0] hs_to_q, ex_to_q, rx_to_q, ack_to_q;
  logic [7:0] send_code_q;

  // Protocol state
  phase_e     phase_q, phase_d;
  logic [7:0] command_q, command_d;
  logic [7:0] remaining_q, remaining_d;
  logic [9:0] elapsed_q, elapsed_d;
  logic [7:0] sum_q, sum_d;
  logic       checked_q, checked_d;

  // Captured item, done flag for the receive end, burst counters
  in_item_t   it_q;
  logic       done_ck_q, done_ck_d;
  logic [3:0] bidx_q, bcnt_q;
  logic [3:0] bcnt_d;

  // Payload memory
  logic [7:0] mem_q [PAYLOAD_DEPTH];
  logic [7:0] rd_q;

  // Output register
  logic       out_valid_q;
  out_item_t  out_q;
  logic       out_free;

  // Evaluation results
  out_item_t  res;
  logic       has_res;
  follow_e    follow;
  logic [7:0] burst_cnt;
  logic [9:0] elapsed_inc;
  logic [9:0] limit;
  logic [7:0] rem_dec;
  logic [7:0] b;

  // Result words for a payload byte and a trailing completion
  out_item_t  pay_word;
  out_item_t  done_word;

  logic [WIDE_W-1:0] load_wide;
  logic [WIDE_W-1:0] rd_wide;
  logic              load_ok;

  assign b           = it_q.byte_value;
  assign out_free    = !out_valid_q || out_ready_i;
  assign burst_cnt   = (remaining_q < BURST_LIM) ? remaining_q : BURST_LIM;
  assign elapsed_inc = (elapsed_q != ELAPSED_MAX) ? elapsed_q + 10'd1 : elapsed_q;
  assign rem_dec     = remaining_q - 8'd1;
  assign load_wide   = {{(WIDE_W-3){1'b0}}, it_q.payload_index};
  assign load_ok     = load_wide < WIDE_W'(PAYLOAD_DEPTH);
  assign rd_wide     = {{(WIDE_W-4){1'b0}}, bidx_q};

  // Phase timeout limit
  always_comb begin
    case (phase_q) inside
      PH_INIT, PH_ECHO: limit = hs_to_q;
      PH_EXEC:          limit = ex_to_q;
      PH_RECV:          limit = rx_to_q;
      default:          limit = ack_to_q;
    endcase
  end

  // Evaluate the captured item against the protocol phase
  always_comb begin
    phase_d     = phase_q;
    command_d   = command_q;
    remaining_d = remaining_q;
    elapsed_d   = elapsed_q;
    sum_d       = sum_q;
    checked_d   = checked_q;
    done_ck_d   = done_ck_q;
    bcnt_d      = bcnt_q;
    res         = '0;
    has_res     = 1'b0;
    follow      = FOLLOW_NONE;
    unique case (it_q.func)
      FUNC_START: begin
        command_d   = it_q.cmd_code;
        remaining_d = it_q.data_length;
        elapsed_d   = '0;
        sum_d       = '0;
        checked_d   = 1'b0;
        phase_d     = PH_INIT;
        res.tx_valid = 1'b1;
        res.tx_byte  = START_BYTE;
        has_res      = 1'b1;
      end
      FUNC_BYTE: begin
        unique case (phase_q) inside
          PH_INIT, PH_ECHO: begin
            if (b != ((phase_q == PH_INIT) ? ACK_BYTE : command_q)) begin
              res.done_res = 1'b1;
              res.status   = STATUS_WRONG;
              phase_d      = PH_IDLE;
            end else begin
              res.tx_valid = 1'b1;
              res.tx_byte  = (phase_q == PH_INIT) ? command_q : ACK_BYTE;
              phase_d      = (phase_q == PH_INIT) ? PH_ECHO : PH_EXEC;
              elapsed_d    = '0;
            end
            has_res = 1'b1;
          end
          PH_EXEC: begin
            if (b != ACK_BYTE) begin
              res.done_res = 1'b1;
              res.status   = STATUS_WRONG;
              has_res      = 1'b1;
              phase_d      = PH_IDLE;
            end else begin
              elapsed_d = '0;
              if (command_q == send_code_q) begin
                phase_d = PH_ACK;
                bcnt_d  = burst_cnt[3:0];
                if (burst_cnt != 8'd0) follow = FOLLOW_BURST;
              end else if (remaining_q == 8'd0) begin
                res.done_res    = 1'b1;
                res.status      = STATUS_OK;
                res.checksum_ok = 1'b1;
                has_res         = 1'b1;
                phase_d         = PH_IDLE;
              end else begin
                checked_d = remaining_q >= 8'd2;
                sum_d     = '0;
                phase_d   = PH_RECV;
              end
            end
          end
          PH_RECV: begin
            res.rx_valid = 1'b1;
            res.rx_out   = b;
            has_res      = 1'b1;
            remaining_d  = rem_dec;
            if (rem_dec == 8'd0) begin
              follow    = FOLLOW_DONE;
              done_ck_d = checked_q ? (sum_q == b) : 1'b1;
              phase_d   = PH_IDLE;
            end else begin
              sum_d = sum_q + b;
            end
          end
          PH_ACK: begin
            res.done_res = 1'b1;
            res.status   = STATUS_OK;
            has_res      = 1'b1;
            phase_d      = PH_IDLE;
          end
          default: ;
        endcase
      end
      FUNC_TICK: begin
        if (phase_q != PH_IDLE) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc > limit) begin
            res.done_res = 1'b1;
            res.status   = STATUS_TIMEOUT;
            has_res      = 1'b1;
            phase_d      = PH_IDLE;
          end
        end
      end
      default: ;
    endcase
    res.last = has_res && (follow == FOLLOW_NONE);
  end

  // Payload byte and completion words
  always_comb begin
    pay_word             = '0;
    pay_word.tx_valid    = 1'b1;
    pay_word.tx_byte     = rd_q;
    pay_word.last        = stat_o.burst_last;
    done_word            = '0;
    done_word.done_res   = 1'b1;
    done_word.status     = STATUS_OK;
    done_word.checksum_ok = done_ck_q;
    done_word.last       = 1'b1;
  end

  // Configuration, protocol state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_to_q     <= HANDSHAKE_TO_RST;
      ex_to_q     <= EXECUTE_TO_RST;
      rx_to_q     <= RECEIVE_TO_RST;
      ack_to_q    <= ACK_TO_RST;
      send_code_q <= SEND_CODE_RST;
      phase_q     <= PH_IDLE;
      command_q   <= '0;
      remaining_q <= '0;
      elapsed_q   <= '0;
      sum_q       <= '0;
      checked_q   <= 1'b0;
      bidx_q      <= '0;
      bcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_HANDSHAKE_TO: hs_to_q     <= cfg_data_i;
          CFG_EXECUTE_TO:   ex_to_q     <= cfg_data_i;
          CFG_RECEIVE_TO:   rx_to_q     <= cfg_data_i;
          CFG_ACK_TO:       ack_to_q    <= cfg_data_i;
          CFG_SEND_CODE:    send_code_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.apply) begin
        phase_q     <= phase_d;
        command_q   <= command_d;
        remaining_q <= remaining_d;
        elapsed_q   <= elapsed_d;
        sum_q       <= sum_d;
        checked_q   <= checked_d;
        bcnt_q      <= bcnt_d;
        bidx_q      <= '0;
      end else if (cmd_i.push_payload) begin
        bidx_q <= bidx_q + 4'd1;
      end
      if (cmd_i.push_payload || cmd_i.push_done || (cmd_i.apply && has_res)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: captured item, output word, memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) it_q <= in_item_i;
    if (cmd_i.apply) done_ck_q <= done_ck_d;
    if (cmd_i.apply && (it_q.func == FUNC_LOAD) && load_ok) begin
      mem_q[load_wide[ADDR_W-1:0]] <= b;
    end
    if (cmd_i.burst_read) rd_q <= mem_q[rd_wide[ADDR_W-1:0]];
    if (cmd_i.apply && has_res) begin
      out_q <= res;
    end else if (cmd_i.push_payload) begin
      out_q <= pay_word;
    end else if (cmd_i.push_done) begin
      out_q <= done_word;
    end
  end

  assign stat_o.out_free   = out_free;
  assign stat_o.follow     = follow;
  assign stat_o.burst_last = (bidx_q + 4'd1) == bcnt_q;
  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;

  // A result is only written when the output register can take it
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push_payload || cmd_i.push_done || (cmd_i.apply && has_res)) |-> out_free)
    else $error("result pushed into a full output register");

  // Payload bursts never run past their count
  a_burst_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_payload |-> (bidx_q < bcnt_q))
    else $error("payload burst index out of range");

  // A start always enters the first handshake phase
  a_start_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && (it_q.func == FUNC_START)) |=> (phase_q == PH_INIT))
    else $error("start did not enter the first handshake phase");

  // A completion never carries an undefined status code
  a_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.done_res) |-> (out_q.status != 2'd3))
    else $error("completion with undefined status");

endmodule

`default_nettype wire

// ===== hw/rtl/reader_command_handshake.sv =====
// Top level of the reader command handshake block.
// Host side of a serial card-reader command exchange.
// Input channel (in_valid_i/in_ready_o, in_item_i): one transfer per event:
//   start command, received byte, millisecond tick or payload load.
// Output channel (out_valid_o/out_ready_i, out_item_o): zero to eight result
//   transfers per input event; the last one of an event has last set.
// Config channel (cfg_valid_i/cfg_ready_o): always ready, writes the four
//   timeout limits and the send command code; write only while idle.
// Sequence: an event is captured while idle and evaluated once the output
//   register is free, which loads any first result into the output register;
//   a trailing completion takes one more output load, and each payload byte of
//   a send burst takes one payload memory read and then one output load.
//   The output register parts the channels: the next event is taken while
//   the last result still waits.
// When the receiver stalls, evaluation waits for the output register to
//   free up; no result is lost or repeated.
// Reset returns to idle with the default limits; payload memory is not
//   cleared and slots must be loaded before they are sent.
`default_nettype none

module reader_command_handshake
  import rch_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_item_t   in_item_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_item_t       out_item_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [9:0] cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rch_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rch_datapath #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
